FILE: rtl/core/assert_macros.svh
// Assertion macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent
`define ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/core/det_pkg.sv
// Types and constants for the directional edge trace block
`timescale 1ns / 1ps

package det_pkg;

  localparam int DEF_MAX_PIXELS = 65536;
  localparam int DEF_MAX_SIDE   = 256;

  localparam int IDX_W      = 16;
  localparam int GREY_W     = 8;
  localparam int GRAD_W     = 11;
  localparam int DIR_W      = 3;
  localparam int SIDE_CFG_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd3;

  localparam logic [SIDE_CFG_W-1:0] RST_IMAGE_WIDTH    = 9'd256;
  localparam logic [SIDE_CFG_W-1:0] RST_IMAGE_HEIGHT   = 9'd256;
  localparam logic [GRAD_W-1:0]     RST_HIGH_THRESHOLD = 11'd60;
  localparam logic [GRAD_W-1:0]     RST_LOW_THRESHOLD  = 11'd30;

  localparam logic [GREY_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [GREY_W-1:0] PIX_BLACK = 8'd0;

  // Walk codes; direction codes at or above DIR_NONE start no walk
  localparam logic [1:0]       DIR_0    = 2'd0;
  localparam logic [1:0]       DIR_45   = 2'd1;
  localparam logic [1:0]       DIR_90   = 2'd2;
  localparam logic [1:0]       DIR_135  = 2'd3;
  localparam logic [DIR_W-1:0] DIR_NONE = 3'd4;

  typedef struct packed {
    logic [GRAD_W-1:0] grad;
    logic [DIR_W-1:0]  dir;
  } gd_word_t;

endpackage

FILE: rtl/core/det_if.sv
// Input and result channel interfaces of the edge trace block
`timescale 1ns / 1ps

interface det_in_if import det_pkg::*;;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [IDX_W-1:0]  pixel_index;
  logic [GREY_W-1:0] grey_level;
  logic [GRAD_W-1:0] gradient_mag;
  logic [DIR_W-1:0]  edge_direction;
  logic              last_pixel;

  modport source (
    output valid, operation, pixel_index, grey_level, gradient_mag, edge_direction,
    last_pixel,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_index, grey_level, gradient_mag, edge_direction,
    last_pixel,
    output ready
  );
  modport mon (
    input valid, ready, operation, pixel_index, grey_level, gradient_mag, edge_direction,
    last_pixel
  );
endinterface

interface det_out_if import det_pkg::*;;
  logic              valid;
  logic              ready;
  logic [GREY_W-1:0] edge_pixel;
  logic              trace_done;

  modport source (output valid, edge_pixel, trace_done, input ready);
  modport sink (input valid, edge_pixel, trace_done, output ready);
  modport mon (input valid, ready, edge_pixel, trace_done);
endinterface

FILE: rtl/core/det_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module det_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/directional_edge_trace_top.sv
// Directional edge trace with hysteresis over a stored image
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------------
//  in_ch   | in  | valid/ready   | operation, pixel_index, grey_level,
//          |     |               | gradient_mag, edge_direction, last_pixel
//  out_ch  | out | valid/ready   | edge_pixel, trace_done
//  cfg     | in  | cfg_we        | cfg_index, cfg_wdata
//
// A read is held pending for the RAM read, and its result is then registered.
// A last load runs the trace: a scan reads and checks each pixel, a strong one
// starts a walk of read and check steps that stops at a failing step or at the
// border, a clean-up pass reads and checks every pixel, then the result posts;
// the gradient/direction RAM's one read port and registered read set this.
// Reset clears control and configuration registers only; the RAMs need no clearing pass.
// A stalled result holds the block; a new item is taken as the result leaves.
`timescale 1ns / 1ps

module directional_edge_trace_top import det_pkg::*; #(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  parameter int MAX_SIDE   = DEF_MAX_SIDE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  det_in_if.sink                in_ch,
  det_out_if.source             out_ch
);

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int POS_W  = 2 * SIDE_W;
  localparam int GD_W   = $bits(gd_word_t);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCAN_RD   = 3'd1;
  localparam logic [2:0] ST_SCAN_CHK  = 3'd2;
  localparam logic [2:0] ST_WALK_STEP = 3'd3;
  localparam logic [2:0] ST_WALK_CHK  = 3'd4;
  localparam logic [2:0] ST_FIN_RD    = 3'd5;
  localparam logic [2:0] ST_FIN_CHK   = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  logic [SIDE_CFG_W-1:0] width_r, height_r;
  logic [GRAD_W-1:0]     high_r, low_r;

  logic [2:0]        state_r, state_nxt;
  logic [SIDE_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [POS_W-1:0]  idx_r, idx_nxt;
  logic [SIDE_W-1:0] wrow_r, wrow_nxt, wcol_r, wcol_nxt;
  logic [POS_W-1:0]  widx_r, widx_nxt;
  logic [1:0]        wcode_r, wcode_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic              done_r, done_nxt;
  logic              gd_rng_r, pix_rng_r;
  logic              out_valid_r, out_valid_nxt;
  logic [GREY_W-1:0] out_pix_r, out_pix_nxt;
  logic              out_done_r, out_done_nxt;

  logic [SIDE_W-1:0] w_eff, h_eff;
  logic              in_ready, in_acc;
  logic              col_last, row_last, scan_end, scan_adv;
  logic              walk_ok;
  logic [SIDE_W-1:0] step_row, step_col;
  logic [POS_W-1:0]  step_idx;
  logic              strong_px, walk_cont;

  logic [POS_W-1:0]  gd_rpos;
  logic              gd_rng_nxt, pix_rng_nxt;
  logic [ADDR_W-1:0] gd_raddr, pix_raddr, pix_waddr;
  logic              gd_we, pix_we;
  logic [GREY_W-1:0] pix_wdata, pix_q;
  logic [GD_W-1:0]   gd_rdata;
  gd_word_t          gd_wdata, gd_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      high_r   <= RST_HIGH_THRESHOLD;
      low_r    <= RST_LOW_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:    width_r  <= cfg_wdata[SIDE_CFG_W-1:0];
        REG_IMAGE_HEIGHT:   height_r <= cfg_wdata[SIDE_CFG_W-1:0];
        REG_HIGH_THRESHOLD: high_r   <= cfg_wdata;
        REG_LOW_THRESHOLD:  low_r    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clamp image sides to 1..MAX_SIDE
  always_comb begin
    if (width_r == '0) begin
      w_eff = SIDE_W'(1);
    end else if (32'(width_r) > 32'(MAX_SIDE)) begin
      w_eff = SIDE_W'(MAX_SIDE);
    end else begin
      w_eff = SIDE_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SIDE_W'(1);
    end else if (32'(height_r) > 32'(MAX_SIDE)) begin
      h_eff = SIDE_W'(MAX_SIDE);
    end else begin
      h_eff = SIDE_W'(height_r);
    end
  end

  assign in_ready     = (state_r == ST_IDLE) && !rd_pend_r && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ready;
  assign in_ch.ready  = in_ready;

  assign gd_q = gd_word_t'(gd_rdata);

  // Raster scan position
  assign col_last = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign row_last = (32'(row_r) + 32'd1) >= 32'(h_eff);
  assign scan_end = col_last && row_last;

  // Walk step from the current walk position
  always_comb begin
    walk_ok = (32'(wrow_r) + 32'd1) < 32'(h_eff);
    if (wcode_r == DIR_135) begin
      walk_ok = walk_ok && (wcol_r != '0);
    end else begin
      walk_ok = walk_ok && ((32'(wcol_r) + 32'd1) < 32'(w_eff));
    end
    case (wcode_r)
      DIR_0: begin
        step_row = wrow_r;
        step_col = wcol_r + SIDE_W'(1);
        step_idx = widx_r + POS_W'(1);
      end
      DIR_45: begin
        step_row = wrow_r + SIDE_W'(1);
        step_col = wcol_r + SIDE_W'(1);
        step_idx = widx_r + POS_W'(w_eff) + POS_W'(1);
      end
      DIR_90: begin
        step_row = wrow_r + SIDE_W'(1);
        step_col = wcol_r;
        step_idx = widx_r + POS_W'(w_eff);
      end
      DIR_135: begin
        step_row = wrow_r + SIDE_W'(1);
        step_col = wcol_r - SIDE_W'(1);
        step_idx = widx_r + POS_W'(w_eff) - POS_W'(1);
      end
      default: begin
        step_row = wrow_r;
        step_col = wcol_r;
        step_idx = widx_r;
      end
    endcase
  end

  assign strong_px = gd_rng_r && (gd_q.grad > high_r) && (gd_q.dir < DIR_NONE);
  assign walk_cont = gd_rng_r && (gd_q.dir == {1'b0, wcode_r}) && (gd_q.grad > low_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    idx_nxt       = idx_r;
    wrow_nxt      = wrow_r;
    wcol_nxt      = wcol_r;
    widx_nxt      = widx_r;
    wcode_nxt     = wcode_r;
    done_nxt      = done_r;
    rd_pend_nxt   = in_acc && (in_ch.operation == OP_READ);
    scan_adv      = 1'b0;
    pix_we        = 1'b0;
    pix_waddr     = ADDR_W'(idx_r);
    pix_wdata     = PIX_BLACK;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pix_nxt   = out_pix_r;
    out_done_nxt  = out_done_r;

    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = pix_rng_r ? pix_q : PIX_BLACK;
      out_done_nxt  = done_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.operation == OP_LOAD)) begin
          pix_we    = 32'(in_ch.pixel_index) < 32'(MAX_PIXELS);
          pix_waddr = ADDR_W'(in_ch.pixel_index);
          pix_wdata = in_ch.grey_level;
          if (in_ch.last_pixel) begin
            row_nxt   = '0;
            col_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = ST_SCAN_RD;
          end else begin
            done_nxt = 1'b0;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (strong_px) begin
          wrow_nxt  = row_r;
          wcol_nxt  = col_r;
          widx_nxt  = idx_r;
          wcode_nxt = gd_q.dir[1:0];
          state_nxt = ST_WALK_STEP;
        end else begin
          pix_we    = gd_rng_r;
          pix_wdata = PIX_BLACK;
          scan_adv  = 1'b1;
        end
      end
      ST_WALK_STEP: begin
        if (walk_ok) begin
          wrow_nxt  = step_row;
          wcol_nxt  = step_col;
          widx_nxt  = step_idx;
          state_nxt = ST_WALK_CHK;
        end else begin
          scan_adv = 1'b1;
        end
      end
      ST_WALK_CHK: begin
        if (walk_cont) begin
          pix_we    = 1'b1;
          pix_waddr = ADDR_W'(widx_r);
          pix_wdata = PIX_WHITE;
          state_nxt = ST_WALK_STEP;
        end else begin
          scan_adv = 1'b1;
        end
      end
      ST_FIN_RD: begin
        state_nxt = ST_FIN_CHK;
      end
      ST_FIN_CHK: begin
        pix_we    = pix_rng_r && (pix_q != PIX_WHITE);
        pix_wdata = PIX_BLACK;
        if (scan_end) begin
          state_nxt = ST_DONE;
        end else begin
          col_nxt   = col_last ? '0 : col_r + SIDE_W'(1);
          row_nxt   = col_last ? row_r + SIDE_W'(1) : row_r;
          idx_nxt   = idx_r + POS_W'(1);
          state_nxt = ST_FIN_RD;
        end
      end
      ST_DONE: begin
        done_nxt      = 1'b1;
        out_valid_nxt = 1'b1;
        out_pix_nxt   = PIX_BLACK;
        out_done_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (scan_adv) begin
      if (scan_end) begin
        row_nxt   = '0;
        col_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = ST_FIN_RD;
      end else begin
        col_nxt   = col_last ? '0 : col_r + SIDE_W'(1);
        row_nxt   = col_last ? row_r + SIDE_W'(1) : row_r;
        idx_nxt   = idx_r + POS_W'(1);
        state_nxt = ST_SCAN_RD;
      end
    end
  end

  // RAM read addresses
  assign gd_rpos    = (state_r == ST_SCAN_RD) ? idx_r : step_idx;
  assign gd_raddr   = ADDR_W'(gd_rpos);
  assign gd_rng_nxt = 32'(gd_rpos) < 32'(MAX_PIXELS);

  always_comb begin
    if (state_r == ST_FIN_RD) begin
      pix_raddr   = ADDR_W'(idx_r);
      pix_rng_nxt = 32'(idx_r) < 32'(MAX_PIXELS);
    end else begin
      pix_raddr   = ADDR_W'(in_ch.pixel_index);
      pix_rng_nxt = 32'(in_ch.pixel_index) < 32'(MAX_PIXELS);
    end
  end

  assign gd_we    = in_acc && (in_ch.operation == OP_LOAD) &&
                    (32'(in_ch.pixel_index) < 32'(MAX_PIXELS));
  assign gd_wdata = '{grad: in_ch.gradient_mag, dir: in_ch.edge_direction};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    idx_r      <= idx_nxt;
    wrow_r     <= wrow_nxt;
    wcol_r     <= wcol_nxt;
    widx_r     <= widx_nxt;
    wcode_r    <= wcode_nxt;
    gd_rng_r   <= gd_rng_nxt;
    pix_rng_r  <= pix_rng_nxt;
    out_pix_r  <= out_pix_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_pixel = out_pix_r;
  assign out_ch.trace_done = out_done_r;

  det_ram #(
    .WIDTH (GREY_W),
    .DEPTH (MAX_PIXELS)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_q)
  );

  det_ram #(
    .WIDTH (GD_W),
    .DEPTH (MAX_PIXELS)
  ) u_gd_ram (
    .clk   (clk),
    .we    (gd_we),
    .waddr (ADDR_W'(in_ch.pixel_index)),
    .wdata (GD_W'(gd_wdata)),
    .raddr (gd_raddr),
    .rdata (gd_rdata)
  );

endmodule

FILE: rtl/core/det_checker.sv
// Port-level assertions for the edge trace block, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module det_checker import det_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  det_in_if.sink    in_ch,
  det_out_if.source out_ch
);

  `ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready,
               out_ch.valid && $stable(out_ch.edge_pixel) && $stable(out_ch.trace_done),
               "result item changed while stalled")
  `ASSERT_NEXT(a_trace_busy,
               in_ch.valid && in_ch.ready && (in_ch.operation == OP_LOAD) && in_ch.last_pixel,
               !in_ch.ready, "item taken while trace starts")
  `ASSERT_NEXT(a_load_silent,
               in_ch.valid && in_ch.ready && (in_ch.operation == OP_LOAD) &&
               !in_ch.last_pixel && !out_ch.valid,
               !out_ch.valid, "plain load produced a result")
  `ASSERT_NEXT(a_read_pend, in_ch.valid && in_ch.ready && (in_ch.operation == OP_READ),
               !in_ch.ready && !out_ch.valid, "read pending cycle broken")
  `ASSERT_NOW(a_ready_free, in_ch.ready, !out_ch.valid || out_ch.ready,
              "ready while result stalled")

endmodule

bind directional_edge_trace_top det_checker u_det_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
